// ----- rtl/core/skt_pkg.sv -----
// ----------------------------------------------------------------------------
// skt_pkg
// Types and codes shared by the sorted keyframe table, its checker and testbench.
// ----------------------------------------------------------------------------
package skt_pkg;

    typedef enum logic
    {
        KIND_INSERT = 1'b0,
        KIND_FIND   = 1'b1
    } kind_t;

    typedef enum logic [1:0]
    {
        STATUS_INSERTED = 2'd0,
        STATUS_FULL     = 2'd1,
        STATUS_FOUND    = 2'd2,
        STATUS_EMPTY    = 2'd3
    } status_t;

    typedef enum logic [2:0]
    {
        S_IDLE,
        S_INS_SCAN,
        S_INS_PUT,
        S_FIND_SCAN,
        S_FIND_DATA,
        S_DONE
    } state_t;

    typedef struct packed
    {
        kind_t              kind;
        logic signed [31:0] key_time;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] pos_w;
        logic signed [15:0] rot_x;
        logic signed [15:0] rot_y;
        logic signed [15:0] rot_z;
        logic signed [15:0] rot_w;
    } req_t;

    typedef struct packed
    {
        status_t            status;
        logic        [3:0]  slot;
        logic        [4:0]  entries;
        logic signed [31:0] found_x;
        logic signed [31:0] found_y;
        logic signed [31:0] found_z;
        logic signed [31:0] found_w;
        logic signed [15:0] found_qx;
        logic signed [15:0] found_qy;
        logic signed [15:0] found_qz;
        logic signed [15:0] found_qw;
    } rsp_t;

    // Keyframe payload as held in the data RAM.
    typedef struct packed
    {
        logic signed [15:0] rot_w;
        logic signed [15:0] rot_z;
        logic signed [15:0] rot_y;
        logic signed [15:0] rot_x;
        logic signed [31:0] pos_w;
        logic signed [31:0] pos_z;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_x;
    } key_data_t;

endpackage

// ----- rtl/core/skt_ram.sv -----
// ----------------------------------------------------------------------------
// skt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module skt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ----- rtl/core/sorted_keyframe_table.sv -----
// ----------------------------------------------------------------------------
// sorted_keyframe_table
// Time-ordered keyframe table with sorted insert and nearest-time lookup.
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+---------------
//   req     | in        | req_valid/req_ready | skt_pkg::req_t
//   rsp     | out       | rsp_valid/rsp_ready | skt_pkg::rsp_t
//
// An insert walks down from the last entry, moving each entry that lies
// after the new key up one slot through the single RAM write port. A read
// that does not move stops the walk, as does moving slot zero; then the
// key is written into the freed slot.
// A lookup reads each stored time in turn through the read / distance /
// compare pipeline, drains it, and ends with a data read of the nearest key.
// A full-table insert and an empty-table lookup go straight to the response.
// Reset clears the key count, state and valid flags; the RAMs are not cleared.
// A stalled response holds in the output register; the next request is taken
// meanwhile and waits in S_DONE only if its own result is ready first.
// ----------------------------------------------------------------------------
module sorted_keyframe_table #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  skt_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output skt_pkg::rsp_t rsp
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int DATA_W = $bits(skt_pkg::key_data_t);
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(TABLE_DEPTH);

    skt_pkg::state_t state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] ptr_reg, ptr_next;
    logic             rsp_valid_reg, rsp_valid_next;
    logic             lat1_vld_reg, lat1_vld_next;
    logic             dist_vld_reg, dist_vld_next;

    skt_pkg::req_t    req_reg, req_next;
    skt_pkg::rsp_t    res_reg, res_next;
    skt_pkg::rsp_t    rsp_reg, rsp_next;
    logic             front_reg, front_next;
    logic [31:0]      first_time_reg, first_time_next;
    logic [IDX_W-1:0] put_reg, put_next;
    logic [IDX_W-1:0] lat1_idx_reg, lat1_idx_next;
    logic [32:0]      dist_reg, dist_next;
    logic [IDX_W-1:0] dist_idx_reg, dist_idx_next;
    logic [32:0]      best_reg, best_next;
    logic [IDX_W-1:0] best_idx_reg, best_idx_next;

    // RAM ports
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    logic [31:0]        wr_time;
    skt_pkg::key_data_t wr_data;
    logic               rd_en;
    logic [IDX_W-1:0]   rd_addr;
    logic [31:0]        time_rd;
    skt_pkg::key_data_t data_rd;

    // helpers
    logic [IDX_W-1:0] idx;
    logic [IDX_W:0]   idx_inc_w;
    logic [IDX_W-1:0] idx_dec;
    logic [CNT_W-1:0] cnt_dec;
    logic [CNT_W-1:0] cnt_inc;
    logic [CNT_W-1:0] ptr_dec;
    logic [CNT_W-1:0] ptr_inc;
    logic             move_up;
    logic             issue;
    logic [32:0]      q_ext;
    logic [32:0]      s_ext;
    logic [32:0]      diff_qs;
    logic [32:0]      diff_sq;
    logic [32:0]      dist_calc;

    skt_ram #(
        .WIDTH (32),
        .DEPTH (TABLE_DEPTH)
    ) u_time_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_time),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (time_rd)
    );

    skt_ram #(
        .WIDTH (DATA_W),
        .DEPTH (TABLE_DEPTH)
    ) u_data_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (data_rd)
    );

    assign idx       = ptr_reg[IDX_W-1:0];
    assign idx_inc_w = {1'b0, idx} + 1'b1;
    assign idx_dec   = idx - 1'b1;
    assign cnt_dec   = count_reg - 1'b1;
    assign cnt_inc   = count_reg + 1'b1;
    assign ptr_dec   = ptr_reg - 1'b1;
    assign ptr_inc   = ptr_reg + 1'b1;

    // Shift this entry up when it lies after the new key. A key at or before
    // the first entry goes to the front, so everything moves.
    assign move_up = front_reg || ($signed(time_rd) > req_reg.key_time);

    assign issue = (ptr_reg < count_reg);

    // Both differences in parallel; the sign of one picks the magnitude.
    assign q_ext     = {req_reg.key_time[31], req_reg.key_time};
    assign s_ext     = {time_rd[31], time_rd};
    assign diff_qs   = q_ext - s_ext;
    assign diff_sq   = s_ext - q_ext;
    assign dist_calc = diff_qs[32] ? diff_sq : diff_qs;

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        ptr_next        = ptr_reg;
        req_next        = req_reg;
        res_next        = res_reg;
        rsp_next        = rsp_reg;
        front_next      = front_reg;
        first_time_next = first_time_reg;
        put_next        = put_reg;
        lat1_vld_next   = 1'b0;
        lat1_idx_next   = lat1_idx_reg;
        dist_vld_next   = 1'b0;
        dist_next       = dist_reg;
        dist_idx_next   = dist_idx_reg;
        best_next       = best_reg;
        best_idx_next   = best_idx_reg;
        wr_en           = 1'b0;
        wr_addr         = '0;
        wr_time         = '0;
        wr_data         = '0;
        rd_en           = 1'b0;
        rd_addr         = '0;

        rsp_valid_next = rsp_valid_reg && !rsp_ready;

        case (state_reg)
            skt_pkg::S_IDLE:
            begin
                if (req_valid)
                begin
                    req_next = req;
                    if (req.kind == skt_pkg::KIND_INSERT)
                    begin
                        if (count_reg == FULL_COUNT)
                        begin
                            res_next         = '0;
                            res_next.status  = skt_pkg::STATUS_FULL;
                            res_next.entries = 5'(count_reg);
                            state_next       = skt_pkg::S_DONE;
                        end
                        else if (count_reg == '0)
                        begin
                            put_next   = '0;
                            state_next = skt_pkg::S_INS_PUT;
                        end
                        else
                        begin
                            // walk down from the last entry
                            ptr_next   = cnt_dec;
                            rd_en      = 1'b1;
                            rd_addr    = cnt_dec[IDX_W-1:0];
                            front_next = (req.key_time <= $signed(first_time_reg));
                            state_next = skt_pkg::S_INS_SCAN;
                        end
                    end
                    else
                    begin
                        if (count_reg == '0)
                        begin
                            res_next        = '0;
                            res_next.status = skt_pkg::STATUS_EMPTY;
                            state_next      = skt_pkg::S_DONE;
                        end
                        else
                        begin
                            ptr_next   = '0;
                            state_next = skt_pkg::S_FIND_SCAN;
                        end
                    end
                end
            end

            skt_pkg::S_INS_SCAN:
            begin
                if (move_up)
                begin
                    wr_en   = 1'b1;
                    wr_addr = idx_inc_w[IDX_W-1:0];
                    wr_time = time_rd;
                    wr_data = data_rd;
                    if (idx == '0)
                    begin
                        put_next   = '0;
                        state_next = skt_pkg::S_INS_PUT;
                    end
                    else
                    begin
                        ptr_next = ptr_dec;
                        rd_en    = 1'b1;
                        rd_addr  = idx_dec;
                    end
                end
                else
                begin
                    put_next   = idx_inc_w[IDX_W-1:0];
                    state_next = skt_pkg::S_INS_PUT;
                end
            end

            skt_pkg::S_INS_PUT:
            begin
                wr_en         = 1'b1;
                wr_addr       = put_reg;
                wr_time       = req_reg.key_time;
                wr_data.pos_x = req_reg.pos_x;
                wr_data.pos_y = req_reg.pos_y;
                wr_data.pos_z = req_reg.pos_z;
                wr_data.pos_w = req_reg.pos_w;
                wr_data.rot_x = req_reg.rot_x;
                wr_data.rot_y = req_reg.rot_y;
                wr_data.rot_z = req_reg.rot_z;
                wr_data.rot_w = req_reg.rot_w;
                if (put_reg == '0)
                begin
                    first_time_next = req_reg.key_time;
                end
                count_next       = cnt_inc;
                res_next         = '0;
                res_next.status  = skt_pkg::STATUS_INSERTED;
                res_next.slot    = 4'(put_reg);
                res_next.entries = 5'(cnt_inc);
                state_next       = skt_pkg::S_DONE;
            end

            skt_pkg::S_FIND_SCAN:
            begin
                if (issue)
                begin
                    rd_en         = 1'b1;
                    rd_addr       = idx;
                    ptr_next      = ptr_inc;
                    lat1_vld_next = 1'b1;
                    lat1_idx_next = idx;
                end
                if (lat1_vld_reg)
                begin
                    dist_vld_next = 1'b1;
                    dist_next     = dist_calc;
                    dist_idx_next = lat1_idx_reg;
                end
                // strict less keeps the earlier key on a tie
                if (dist_vld_reg && ((dist_idx_reg == '0) || (dist_reg < best_reg)))
                begin
                    best_next     = dist_reg;
                    best_idx_next = dist_idx_reg;
                end
                if (!issue && !lat1_vld_reg && !dist_vld_reg)
                begin
                    rd_en      = 1'b1;
                    rd_addr    = best_idx_reg;
                    state_next = skt_pkg::S_FIND_DATA;
                end
            end

            skt_pkg::S_FIND_DATA:
            begin
                res_next          = '0;
                res_next.status   = skt_pkg::STATUS_FOUND;
                res_next.slot     = 4'(best_idx_reg);
                res_next.entries  = 5'(count_reg);
                res_next.found_x  = data_rd.pos_x;
                res_next.found_y  = data_rd.pos_y;
                res_next.found_z  = data_rd.pos_z;
                res_next.found_w  = data_rd.pos_w;
                res_next.found_qx = data_rd.rot_x;
                res_next.found_qy = data_rd.rot_y;
                res_next.found_qz = data_rd.rot_z;
                res_next.found_qw = data_rd.rot_w;
                state_next        = skt_pkg::S_DONE;
            end

            skt_pkg::S_DONE:
            begin
                // hold until the output register is free
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_next       = res_reg;
                    rsp_valid_next = 1'b1;
                    state_next     = skt_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = skt_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= skt_pkg::S_IDLE;
            count_reg     <= '0;
            ptr_reg       <= '0;
            rsp_valid_reg <= 1'b0;
            lat1_vld_reg  <= 1'b0;
            dist_vld_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            ptr_reg       <= ptr_next;
            rsp_valid_reg <= rsp_valid_next;
            lat1_vld_reg  <= lat1_vld_next;
            dist_vld_reg  <= dist_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg        <= req_next;
        res_reg        <= res_next;
        rsp_reg        <= rsp_next;
        front_reg      <= front_next;
        first_time_reg <= first_time_next;
        put_reg        <= put_next;
        lat1_idx_reg   <= lat1_idx_next;
        dist_reg       <= dist_next;
        dist_idx_reg   <= dist_idx_next;
        best_reg       <= best_next;
        best_idx_reg   <= best_idx_next;
    end

    assign req_ready = (state_reg == skt_pkg::S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

// ----- rtl/core/skt_checker.sv -----
// ----------------------------------------------------------------------------
// skt_checker
// Port-level checks for the sorted keyframe table, bound to the top level.
// ----------------------------------------------------------------------------
module skt_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          req_valid,
    input logic          req_ready,
    input skt_pkg::req_t req,
    input logic          rsp_valid,
    input logic          rsp_ready,
    input skt_pkg::rsp_t rsp
);

    // A stalled response stays up.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("response dropped while stalled");

    // A stalled response does not change.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> $stable(rsp))
        else $error("response changed while stalled");

    // Every taken request leaves S_IDLE, so ready drops after a take.
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while previous one in flight");

    // An empty lookup reports no slot, no keys and zero found_x and found_qw.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.status == skt_pkg::STATUS_EMPTY) |->
            (rsp.slot == '0) && (rsp.entries == '0) && (rsp.found_x == '0)
            && (rsp.found_qw == '0))
        else $error("empty lookup carries data");

    // A dropped insert reports slot zero and zero found_x and found_qx.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.status == skt_pkg::STATUS_FULL) |->
            (rsp.slot == '0) && (rsp.found_x == '0) && (rsp.found_qx == '0))
        else $error("dropped insert carries data");

endmodule

bind sorted_keyframe_table skt_checker u_skt_checker (.*);

// ----- tb/sv/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Testbench for sorted_keyframe_table. A scripted run fills the table through
// every placement case, then random lookups and dropped inserts follow. A
// shadow copy of the keyframe table predicts every response but typed script rows.
// ----------------------------------------------------------------------------
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    import skt_pkg::*;

    localparam int TABLE_DEPTH  = 16;
    localparam int RANDOM_ITEMS = 900;
    localparam int STALL_LIMIT  = 1000;
    localparam int TAIL_CYCLES  = 40;

    typedef struct packed
    {
        kind_t       kind;
        logic [31:0] key_time;
        logic [31:0] fill;
        logic        typed;
        status_t     status;
        logic [3:0]  slot;
        logic [4:0]  entries;
    } script_row_t;

    // Rows with typed set carry their response; the rest go through the shadow table.
    localparam int SCRIPT_LEN = 25;
    localparam script_row_t SCRIPT [SCRIPT_LEN] = '{
        '{KIND_FIND,   32'h0000_0000, 32'hFFFF_FFFF, 1'b1, STATUS_EMPTY,    4'd0, 5'd0},
        '{KIND_INSERT, 32'h0000_0000, 32'h0000_0000, 1'b1, STATUS_INSERTED, 4'd0, 5'd1},
        '{KIND_INSERT, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1, STATUS_INSERTED, 4'd1, 5'd2},
        '{KIND_INSERT, 32'h8000_0000, 32'h8000_0000, 1'b1, STATUS_INSERTED, 4'd0, 5'd3},
        '{KIND_INSERT, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1, STATUS_INSERTED, 4'd0, 5'd4},
        '{KIND_INSERT, 32'h0000_0000, 32'h0F0F_0F0F, 1'b0, STATUS_INSERTED, 4'd0, 5'd0},
        '{KIND_INSERT, 32'h7FFF_FFFF, 32'hF0F0_F0F0, 1'b0, STATUS_INSERTED, 4'd0, 5'd0},
        '{KIND_FIND,   32'h7FFF_FFFF, 32'h0000_0000, 1'b0, STATUS_INSERTED, 4'd0, 5'd0},
        '{KIND_FIND,   32'h8000_0000, 32'hFFFF_FFFF, 1'b0, STATUS_INSERTED, 4'd0, 5'd0},
        '{KIND_FIND,   32'h4000_0000, 32'h0000_0000, 1'b0, STATUS_INSERTED, 4'd0, 5'd0},
        '{KIND_FIND,   32'hFFFF_FFFF, 32'h0000_0000, 1'b0, STATUS_INSERTED, 4'd0, 5'd0},
        '{KIND_INSERT, 32'h0001_0000, 32'h1234_5678, 1'b0, STATUS_INSERTED, 4'd0, 5'd0},
        '{KIND_INSERT, 32'h0003_0000, 32'h8765_4321, 1'b0, STATUS_INSERTED, 4'd0, 5'd0},
        '{KIND_FIND,   32'h0002_0000, 32'h0000_0000, 1'b0, STATUS_INSERTED, 4'd0, 5'd0},
        '{KIND_INSERT, 32'h0002_0000, 32'h5A5A_5A5A, 1'b0, STATUS_INSERTED, 4'd0, 5'd0},
        '{KIND_INSERT, 32'h0000_0000, 32'hA5A5_A5A5, 1'b0, STATUS_INSERTED, 4'd0, 5'd0},
        '{KIND_INSERT, 32'hFFFF_0000, 32'h3C3C_3C3C, 1'b0, STATUS_INSERTED, 4'd0, 5'd0},
        '{KIND_INSERT, 32'h0001_0000, 32'hC3C3_C3C3, 1'b0, STATUS_INSERTED, 4'd0, 5'd0},
        '{KIND_INSERT, 32'hC000_0000, 32'h0123_4567, 1'b0, STATUS_INSERTED, 4'd0, 5'd0},
        '{KIND_INSERT, 32'h3FFF_FFFF, 32'hFEDC_BA98, 1'b0, STATUS_INSERTED, 4'd0, 5'd0},
        '{KIND_INSERT, 32'h7FFF_FFFE, 32'h55AA_55AA, 1'b0, STATUS_INSERTED, 4'd0, 5'd0},
        '{KIND_INSERT, 32'h8000_0001, 32'hAA55_AA55, 1'b0, STATUS_INSERTED, 4'd0, 5'd0},
        '{KIND_INSERT, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1, STATUS_FULL,     4'd0, 5'd16},
        '{KIND_FIND,   32'h0000_0000, 32'h0000_0000, 1'b0, STATUS_INSERTED, 4'd0, 5'd0},
        '{KIND_FIND,   32'h7FFF_FFFF, 32'h0000_0000, 1'b0, STATUS_INSERTED, 4'd0, 5'd0}
    };

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    logic req_ready;
    req_t req       = '0;
    logic rsp_valid;
    logic rsp_ready = 1'b0;
    rsp_t rsp;

    // Shadow of the keyframe table
    logic signed [31:0] key_times  [TABLE_DEPTH];
    key_data_t          key_frames [TABLE_DEPTH];
    int                 key_total = 0;

    rsp_t awaited_results [$];
    int   mismatches  = 0;
    int   quiet_cycles = 0;
    bit   calm = 1'b0;

    sorted_keyframe_table #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    always #1 clk = ~clk;

    function automatic int wait_cycles();
        return calm ? 0 : $urandom_range(0, 12);
    endfunction

    // Apply one request to the shadow table and return the response it causes.
    function automatic rsp_t place_or_find(req_t r);
        rsp_t   res;
        int     landing;
        int     i;
        int     best_slot;
        longint best_gap;
        longint gap_now;
        res = '0;
        if (r.kind == KIND_INSERT)
        begin
            if (key_total >= TABLE_DEPTH)
            begin
                res.status  = STATUS_FULL;
                res.entries = 5'(key_total);
                return res;
            end
            landing = 0;
            if (key_total > 0 && r.key_time > key_times[0])
            begin
                while (landing < key_total && key_times[landing] <= r.key_time)
                    landing++;
            end
            for (i = key_total; i > landing; i--)
            begin
                key_times[i]  = key_times[i - 1];
                key_frames[i] = key_frames[i - 1];
            end
            key_times[landing]        = r.key_time;
            key_frames[landing].pos_x = r.pos_x;
            key_frames[landing].pos_y = r.pos_y;
            key_frames[landing].pos_z = r.pos_z;
            key_frames[landing].pos_w = r.pos_w;
            key_frames[landing].rot_x = r.rot_x;
            key_frames[landing].rot_y = r.rot_y;
            key_frames[landing].rot_z = r.rot_z;
            key_frames[landing].rot_w = r.rot_w;
            key_total++;
            res.status  = STATUS_INSERTED;
            res.slot    = 4'(landing);
            res.entries = 5'(key_total);
            return res;
        end
        if (key_total == 0)
        begin
            res.status = STATUS_EMPTY;
            return res;
        end
        best_slot = 0;
        best_gap  = longint'(r.key_time) - longint'(key_times[0]);
        if (best_gap < 0)
            best_gap = -best_gap;
        for (i = 1; i < key_total; i++)
        begin
            gap_now = longint'(r.key_time) - longint'(key_times[i]);
            if (gap_now < 0)
                gap_now = -gap_now;
            // strict compare: the earlier key keeps a tie
            if (gap_now < best_gap)
            begin
                best_gap  = gap_now;
                best_slot = i;
            end
        end
        res.status   = STATUS_FOUND;
        res.slot     = 4'(best_slot);
        res.entries  = 5'(key_total);
        res.found_x  = key_frames[best_slot].pos_x;
        res.found_y  = key_frames[best_slot].pos_y;
        res.found_z  = key_frames[best_slot].pos_z;
        res.found_w  = key_frames[best_slot].pos_w;
        res.found_qx = key_frames[best_slot].rot_x;
        res.found_qy = key_frames[best_slot].rot_y;
        res.found_qz = key_frames[best_slot].rot_z;
        res.found_qw = key_frames[best_slot].rot_w;
        return res;
    endfunction

    // Offer one request, hold it until taken, then queue its response.
    task automatic push_request(req_t r, bit typed, rsp_t fixed);
        int   gap;
        rsp_t due;
        gap = wait_cycles();
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req       <= r;
        req_valid <= 1'b1;
        do
            @(posedge clk);
        while (!req_ready);
        due = place_or_find(r);
        if (typed)
            due = fixed;
        awaited_results = {awaited_results, due};
    endtask

    function automatic void check_field(string name, longint due, longint got);
        if (due != got)
        begin
            $error("%s: expected %0d, got %0d", name, due, got);
            mismatches++;
        end
    endfunction

    always @(posedge clk)
    begin : rsp_check
        rsp_t due;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (awaited_results.size() == 0)
            begin
                $error("response with no request outstanding");
                mismatches++;
            end
            else
            begin
                due = awaited_results.pop_front();
                check_field("status",   due.status,   rsp.status);
                check_field("slot",     due.slot,     rsp.slot);
                check_field("entries",  due.entries,  rsp.entries);
                check_field("found_x",  due.found_x,  rsp.found_x);
                check_field("found_y",  due.found_y,  rsp.found_y);
                check_field("found_z",  due.found_z,  rsp.found_z);
                check_field("found_w",  due.found_w,  rsp.found_w);
                check_field("found_qx", due.found_qx, rsp.found_qx);
                check_field("found_qy", due.found_qy, rsp.found_qy);
                check_field("found_qz", due.found_qz, rsp.found_qz);
                check_field("found_qw", due.found_qw, rsp.found_qw);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("FAIL sorted_keyframe_table");
            $finish;
        end
    end

    initial
    begin : rsp_side
        int stall;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            stall = wait_cycles();
            if (stall > 0)
            begin
                rsp_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_ready <= 1'b1;
            do
                @(posedge clk);
            while (!rsp_valid);
        end
    end

    initial
    begin : req_side
        req_t        r;
        rsp_t        fixed;
        script_row_t row;
        int          n;
        int          k;
        int          pick;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (n = 0; n < SCRIPT_LEN; n++)
        begin
            row        = SCRIPT[n];
            r.kind     = row.kind;
            r.key_time = row.key_time;
            r.pos_x    = row.fill;
            r.pos_y    = ~row.fill;
            r.pos_z    = {row.fill[15:0], row.fill[31:16]};
            r.pos_w    = row.fill ^ 32'h5555_5555;
            r.rot_x    = row.fill[31:16];
            r.rot_y    = row.fill[15:0];
            r.rot_z    = ~row.fill[31:16];
            r.rot_w    = ~row.fill[15:0];
            fixed         = '0;
            fixed.status  = row.status;
            fixed.slot    = row.slot;
            fixed.entries = row.entries;
            push_request(r, row.typed, fixed);
        end

        // Table is full from here on: inserts drop; key times are random, near a key or between neighbors.
        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            calm   = (n % 160) >= 120;
            r.kind = ($urandom_range(0, 3) == 0) ? KIND_INSERT : KIND_FIND;
            pick   = $urandom_range(0, 9);
            if (pick < 4 || key_total < 2)
                r.key_time = $urandom();
            else if (pick < 8)
            begin
                k = $urandom_range(0, key_total - 1);
                r.key_time = key_times[k] + 32'($urandom_range(0, 6)) - 32'sd3;
            end
            else
            begin
                // midpoint of neighbors: ties when the spacing is even
                k = $urandom_range(0, key_total - 2);
                r.key_time = 32'((longint'(key_times[k]) + longint'(key_times[k + 1])) >>> 1);
            end
            r.pos_x = $urandom();
            r.pos_y = $urandom();
            r.pos_z = $urandom();
            r.pos_w = $urandom();
            r.rot_x = 16'($urandom());
            r.rot_y = 16'($urandom());
            r.rot_z = 16'($urandom());
            r.rot_w = 16'($urandom());
            push_request(r, 1'b0, '0);
        end
        req_valid <= 1'b0;

        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("PASS sorted_keyframe_table");
        else
            $display("FAIL sorted_keyframe_table");
        $finish;
    end

endmodule
